// File: rtl/tor_pkg.sv
`timescale 1ns / 1ps

package tor_pkg;

  localparam int CoordBits = 11;
  localparam int TermBits  = CoordBits + 3;
  localparam int ColorBits = 24;
  localparam int EdgeBits  = 2;
  localparam int NumVerts  = 3;
  localparam int VtxBits   = 2;

  // Input item kinds
  localparam logic FuncAdd  = 1'b0;
  localparam logic FuncStep = 1'b1;

  localparam logic [EdgeBits-1:0] EdgeV1V2 = 2'd0;
  localparam logic [EdgeBits-1:0] EdgeV1V3 = 2'd1;
  localparam logic [EdgeBits-1:0] EdgeV2V3 = 2'd2;

  localparam logic [VtxBits-1:0] Vtx1 = 2'd0;
  localparam logic [VtxBits-1:0] Vtx2 = 2'd1;
  localparam logic [VtxBits-1:0] Vtx3 = 2'd2;

  typedef struct packed {
    logic                 is_step;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
  } cmd_t;

  function automatic logic [VtxBits-1:0] edge_start(input logic [EdgeBits-1:0] e);
    logic [VtxBits-1:0] v;
    unique case (e)
      EdgeV1V2: v = Vtx1;
      EdgeV1V3: v = Vtx1;
      EdgeV2V3: v = Vtx2;
      default:  v = Vtx1;
    endcase
    return v;
  endfunction

  function automatic logic [VtxBits-1:0] edge_end(input logic [EdgeBits-1:0] e);
    logic [VtxBits-1:0] v;
    unique case (e)
      EdgeV1V2: v = Vtx2;
      EdgeV1V3: v = Vtx3;
      EdgeV2V3: v = Vtx3;
      default:  v = Vtx1;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/tor_front.sv
`timescale 1ns / 1ps

module tor_front import tor_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [CoordBits-1:0] in_vertex_x,
  input  logic [CoordBits-1:0] in_vertex_y,
  output logic                 q_valid,
  output cmd_t                 q_cmd,
  input  logic                 q_pop
);

  localparam logic [1:0] QDepth = 2'd2;

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  assign in_ready = (cnt_r != QDepth);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = fifo_r[rd_ptr_r];

  // classify: a step carries no coordinates
  always_comb begin
    cmd_in.is_step = (in_func == FuncStep);
    cmd_in.x       = (in_func == FuncAdd) ? in_vertex_x : '0;
    cmd_in.y       = (in_func == FuncAdd) ? in_vertex_y : '0;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/tor_back.sv
`timescale 1ns / 1ps

module tor_back import tor_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  input  logic [ColorBits-1:0] pen_color,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pixel_valid,
  output logic [CoordBits-1:0] out_pixel_x,
  output logic [CoordBits-1:0] out_pixel_y,
  output logic [ColorBits-1:0] out_pixel_color,
  output logic [EdgeBits-1:0]  out_edge_number,
  output logic                 out_done_res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LD_A = 3'd1;
  localparam logic [2:0] S_LD_B = 3'd2;
  localparam logic [2:0] S_LD_C = 3'd3;
  localparam logic [2:0] S_LD_D = 3'd4;
  localparam logic [2:0] S_DRAW = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam int DBits = CoordBits + 1;

  logic [2*CoordBits-1:0] vmem [NumVerts];
  logic [2*CoordBits-1:0] rdata_r;
  logic [VtxBits-1:0]     rd_addr;
  logic                   vwr;

  logic [2:0]              state_r, state_nxt;
  logic [VtxBits-1:0]      vcount_r, vcount_nxt;
  logic [EdgeBits-1:0]     edge_r, edge_nxt;
  logic [CoordBits-1:0]    sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CoordBits-1:0]    ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [DBits-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [CoordBits-1:0]    cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [TermBits-1:0] term_r, term_nxt;
  logic signed [TermBits-1:0] inc_a_r, inc_a_nxt, inc_b_r, inc_b_nxt;
  logic [CoordBits-1:0]    left_r, left_nxt;
  logic                    xmaj_r, xmaj_nxt, mneg_r, mneg_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    o_pv_r, o_pv_nxt, o_done_r, o_done_nxt;
  logic [CoordBits-1:0]    o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic [ColorBits-1:0]    o_col_r, o_col_nxt;
  logic [EdgeBits-1:0]     o_edge_r, o_edge_nxt;

  // edge setup terms
  logic signed [DBits-1:0] dx_abs, dy_abs, dmin_s;
  logic [CoordBits-1:0]    adx, ady, amaj, amin;
  logic                    xm, swap, dmin_pos;
  logic [TermBits-1:0]     amin2, amaj1, amaj2;
  logic                    slot_free, step_minor;
  logic [CoordBits-1:0]    mstep;

  assign slot_free = !out_valid_r || out_ready;
  assign rd_addr   = (state_r == S_LD_A) ? edge_start(edge_r) : edge_end(edge_r);
  assign vwr       = (state_r == S_IDLE) && q_valid && !q_cmd.is_step;

  always_ff @(posedge clk) begin
    if (vwr) begin
      vmem[vcount_r] <= {q_cmd.x, q_cmd.y};
    end
    rdata_r <= vmem[rd_addr];
  end

  always_comb begin
    dx_abs   = dx_r[DBits-1] ? -dx_r : dx_r;
    dy_abs   = dy_r[DBits-1] ? -dy_r : dy_r;
    adx      = dx_abs[CoordBits-1:0];
    ady      = dy_abs[CoordBits-1:0];
    xm       = adx > ady;
    swap     = xm ? dx_r[DBits-1] : dy_r[DBits-1];
    amaj     = xm ? adx : ady;
    amin     = xm ? ady : adx;
    dmin_s   = xm ? dy_r : dx_r;
    dmin_pos = !dmin_s[DBits-1] && (dmin_s != '0);
    amin2    = {2'b00, amin, 1'b0};
    amaj1    = {3'b000, amaj};
    amaj2    = {2'b00, amaj, 1'b0};
    step_minor = !term_r[TermBits-1] && (term_r != '0);
    mstep    = mneg_r ? '1 : CoordBits'(1);
  end

  always_comb begin
    state_nxt  = state_r;
    vcount_nxt = vcount_r;
    edge_nxt   = edge_r;
    sx_nxt = sx_r; sy_nxt = sy_r; ex_nxt = ex_r; ey_nxt = ey_r;
    dx_nxt = dx_r; dy_nxt = dy_r;
    cur_x_nxt = cur_x_r; cur_y_nxt = cur_y_r;
    term_nxt = term_r; inc_a_nxt = inc_a_r; inc_b_nxt = inc_b_r;
    left_nxt = left_r; xmaj_nxt = xmaj_r; mneg_nxt = mneg_r;
    q_pop = 1'b0;

    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    o_pv_nxt = o_pv_r; o_done_nxt = o_done_r;
    o_x_nxt = o_x_r; o_y_nxt = o_y_r; o_col_nxt = o_col_r; o_edge_nxt = o_edge_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          // steps while idle are dropped
          q_pop = 1'b1;
          if (!q_cmd.is_step) begin
            if (vcount_r == Vtx3) begin
              vcount_nxt = Vtx1;
              edge_nxt   = EdgeV1V2;
              state_nxt  = S_LD_A;
            end else begin
              vcount_nxt = vcount_r + VtxBits'(1);
            end
          end
        end
      end
      S_LD_A: state_nxt = S_LD_B;
      S_LD_B: begin
        sx_nxt    = rdata_r[2*CoordBits-1:CoordBits];
        sy_nxt    = rdata_r[CoordBits-1:0];
        state_nxt = S_LD_C;
      end
      S_LD_C: begin
        ex_nxt    = rdata_r[2*CoordBits-1:CoordBits];
        ey_nxt    = rdata_r[CoordBits-1:0];
        dx_nxt    = $signed({1'b0, rdata_r[2*CoordBits-1:CoordBits]}) - $signed({1'b0, sx_r});
        dy_nxt    = $signed({1'b0, rdata_r[CoordBits-1:0]}) - $signed({1'b0, sy_r});
        state_nxt = S_LD_D;
      end
      S_LD_D: begin
        xmaj_nxt  = xm;
        mneg_nxt  = swap ? dmin_pos : dmin_s[DBits-1];
        cur_x_nxt = swap ? ex_r : sx_r;
        cur_y_nxt = swap ? ey_r : sy_r;
        term_nxt  = $signed(amin2 - amaj1);
        inc_a_nxt = $signed(amin2);
        inc_b_nxt = $signed(amin2 - amaj2);
        left_nxt  = amaj;
        // skip a zero-length edge
        if (amaj != '0) begin
          state_nxt = S_DRAW;
        end else if (edge_r == EdgeV2V3) begin
          state_nxt = S_DONE;
        end else begin
          edge_nxt  = edge_r + EdgeBits'(1);
          state_nxt = S_LD_A;
        end
      end
      S_DRAW: begin
        if (q_valid && !q_cmd.is_step) begin
          q_pop = 1'b1;
        end else if (q_valid && slot_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          o_pv_nxt      = 1'b1;
          o_done_nxt    = 1'b0;
          o_x_nxt       = cur_x_r;
          o_y_nxt       = cur_y_r;
          o_col_nxt     = pen_color;
          o_edge_nxt    = edge_r;
          if (step_minor) begin
            term_nxt = term_r + inc_b_r;
            if (xmaj_r) cur_y_nxt = cur_y_r + mstep;
            else        cur_x_nxt = cur_x_r + mstep;
          end else begin
            term_nxt = term_r + inc_a_r;
          end
          if (xmaj_r) cur_x_nxt = cur_x_r + CoordBits'(1);
          else        cur_y_nxt = cur_y_r + CoordBits'(1);
          left_nxt = left_r - CoordBits'(1);
          if (left_r == CoordBits'(1)) begin
            if (edge_r == EdgeV2V3) begin
              state_nxt = S_DONE;
            end else begin
              edge_nxt  = edge_r + EdgeBits'(1);
              state_nxt = S_LD_A;
            end
          end
        end
      end
      S_DONE: begin
        if (q_valid && !q_cmd.is_step) begin
          q_pop = 1'b1;
        end else if (q_valid && slot_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          o_pv_nxt      = 1'b0;
          o_done_nxt    = 1'b1;
          o_x_nxt       = '0;
          o_y_nxt       = '0;
          o_col_nxt     = '0;
          o_edge_nxt    = EdgeV1V2;
          edge_nxt      = EdgeV1V2;
          left_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sx_r <= sx_nxt; sy_r <= sy_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt;
    inc_a_r <= inc_a_nxt; inc_b_r <= inc_b_nxt;
    o_pv_r <= o_pv_nxt; o_done_r <= o_done_nxt;
    o_x_r <= o_x_nxt; o_y_r <= o_y_nxt; o_col_r <= o_col_nxt; o_edge_r <= o_edge_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= Vtx1;
      edge_r      <= EdgeV1V2;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      term_r      <= '0;
      left_r      <= '0;
      xmaj_r      <= 1'b0;
      mneg_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      edge_r      <= edge_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      term_r      <= term_nxt;
      left_r      <= left_nxt;
      xmaj_r      <= xmaj_nxt;
      mneg_r      <= mneg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = o_pv_r;
  assign out_pixel_x     = o_x_r;
  assign out_pixel_y     = o_y_r;
  assign out_pixel_color = o_col_r;
  assign out_edge_number = o_edge_r;
  assign out_done_res    = o_done_r;

endmodule

// File: rtl/triangle_outline_rasterizer.sv
`timescale 1ns / 1ps

// Triangle outline rasterizer. Three add-vertex items load v1, v2, v3; the
// outline is then drawn as the midpoint lines v1-v2, v1-v3, v2-v3, and each
// step item returns the next pixel (pen_color, edge number) or, once the
// outline is finished, one done result. Add and step items go through a
// two-entry queue into the drawing engine, which takes one queued item per
// cycle while not setting up an edge and, for a pixel or done result, while
// the output register is free. Before each edge the engine sets it up (two
// reads of the vertex store, which has one read port, then delta and
// decision-term set-up); the first pixel waits for it after the third vertex
// and each edge change, skipped zero-length edges too, repeats it; step items
// queue meanwhile. Results sit in an output register; a stalled consumer
// holds the engine, and the input side stalls once the queue is full.
module triangle_outline_rasterizer import tor_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [CoordBits-1:0] in_vertex_x,
  input  logic [CoordBits-1:0] in_vertex_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pixel_valid,
  output logic [CoordBits-1:0] out_pixel_x,
  output logic [CoordBits-1:0] out_pixel_y,
  output logic [ColorBits-1:0] out_pixel_color,
  output logic [EdgeBits-1:0]  out_edge_number,
  output logic                 out_done_res,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam logic RegPenColor = 1'b0;

  logic [ColorBits-1:0] pen_color_r, pen_color_nxt;
  logic                 cfg_wr;
  logic                 q_valid;
  logic                 q_pop;
  cmd_t                 q_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    pen_color_nxt = pen_color_r;
    if (cfg_wr && (cfg_paddr[2] == RegPenColor)) begin
      pen_color_nxt = cfg_pwdata[ColorBits-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == RegPenColor) ? {8'd0, pen_color_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_color_r <= '0;
    end else begin
      pen_color_r <= pen_color_nxt;
    end
  end

  tor_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_vertex_x (in_vertex_x),
    .in_vertex_y (in_vertex_y),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  tor_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .pen_color       (pen_color_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_edge_number (out_edge_number),
    .out_done_res    (out_done_res)
  );

endmodule

// File: test/triangle_outline_rasterizer_tb.sv
`timescale 1ns / 1ps

module triangle_outline_rasterizer_tb;
  import tor_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 40;
  localparam int RandomItems = 2000;
  localparam logic [2:0] PenColorAddr = 3'd0;

  typedef enum logic [1:0] {ExpNone, ExpDone, ExpPixel, ExpModel} row_kind_t;

  typedef struct packed {
    logic                 func;
    logic [CoordBits-1:0] vx;
    logic [CoordBits-1:0] vy;
    row_kind_t            kind;
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    logic [EdgeBits-1:0]  edge_no;
    logic [4:0]           reps;
  } stim_row_t;

  typedef struct packed {
    logic                 pixel_valid;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [ColorBits-1:0] color;
    logic [EdgeBits-1:0]  edge_no;
    logic                 done;
  } pixel_res_t;

  // Degenerate triangle, a tiny one at the top corner with a tie edge, then a
  // shallow one with a zero-length middle edge left to the predictor.
  localparam stim_row_t DirectedRows [23] = '{
    '{FuncStep, 0,    0,    ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  0,    0,    ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  0,    0,    ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  0,    0,    ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncStep, 0,    0,    ExpDone,  0,    0,    EdgeV1V2, 1},
    '{FuncStep, 0,    0,    ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  2047, 2047, ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  2045, 2047, ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  2047, 2045, ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  0,    0,    ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncStep, 0,    0,    ExpPixel, 2045, 2047, EdgeV1V2, 1},
    '{FuncStep, 0,    0,    ExpPixel, 2046, 2047, EdgeV1V2, 1},
    '{FuncStep, 0,    0,    ExpPixel, 2047, 2045, EdgeV1V3, 1},
    '{FuncAdd,  1,    1,    ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncStep, 0,    0,    ExpPixel, 2047, 2046, EdgeV1V3, 1},
    '{FuncStep, 0,    0,    ExpPixel, 2047, 2045, EdgeV2V3, 1},
    '{FuncStep, 0,    0,    ExpPixel, 2046, 2046, EdgeV2V3, 1},
    '{FuncStep, 0,    0,    ExpDone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  10,   20,   ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  17,   17,   ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncAdd,  10,   20,   ExpNone,  0,    0,    EdgeV1V2, 1},
    '{FuncStep, 0,    0,    ExpModel, 0,    0,    EdgeV1V2, 15},
    '{FuncStep, 0,    0,    ExpNone,  0,    0,    EdgeV1V2, 1}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_func;
  logic [CoordBits-1:0] in_vertex_x;
  logic [CoordBits-1:0] in_vertex_y;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_pixel_valid;
  logic [CoordBits-1:0] out_pixel_x;
  logic [CoordBits-1:0] out_pixel_y;
  logic [ColorBits-1:0] out_pixel_color;
  logic [EdgeBits-1:0]  out_edge_number;
  logic                 out_done_res;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [2:0]           cfg_paddr;
  logic [31:0]          cfg_pwdata;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  triangle_outline_rasterizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_edge_number (out_edge_number),
    .out_done_res    (out_done_res),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  // Rasterizer state as the predictor sees it
  logic [CoordBits-1:0] vtx_x [NumVerts];
  logic [CoordBits-1:0] vtx_y [NumVerts];
  int                   vtx_count;
  bit                   drawing_q;
  int                   edge_q;
  logic [CoordBits-1:0] cur_x;
  logic [CoordBits-1:0] cur_y;
  int                   decision;
  int                   steps_left;
  int                   d_major;
  int                   d_minor;
  bit                   xmaj;
  bit                   minor_neg;
  logic [ColorBits-1:0] pen_q;

  pixel_res_t expected_pixels [$];
  int         errors;
  int         useful;
  int         cycles;
  int         pixels_seen;
  int         dones_seen;
  int         colours_written;
  int         triangles_sent;
  bit         calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_pixels.size());
      $display("triangle_outline_rasterizer_tb: FAIL");
      $finish;
    end
  end

  function automatic bit load_segment(int e);
    int sx, sy, ex, ey, t, major, minor;
    int a;
    int b;
    a  = (e == EdgeV2V3) ? Vtx2 : Vtx1;
    b  = (e == EdgeV1V2) ? Vtx2 : Vtx3;
    sx = vtx_x[a];
    sy = vtx_y[a];
    ex = vtx_x[b];
    ey = vtx_y[b];
    xmaj = ((ex > sx) ? ex - sx : sx - ex) > ((ey > sy) ? ey - sy : sy - ey);
    // swap so that the major axis increases
    if (xmaj ? (sx > ex) : (sy > ey)) begin
      t = sx; sx = ex; ex = t;
      t = sy; sy = ey; ey = t;
    end
    major = xmaj ? ex - sx : ey - sy;
    minor = xmaj ? ey - sy : ex - sx;
    minor_neg = minor < 0;
    if (minor < 0) minor = -minor;
    d_major    = major;
    d_minor    = minor;
    decision   = 2 * minor - major;
    steps_left = major;
    cur_x      = sx[CoordBits-1:0];
    cur_y      = sy[CoordBits-1:0];
    return major != 0;
  endfunction

  function automatic void find_segment(int e);
    while (e < 3) begin
      if (load_segment(e)) begin
        edge_q = e;
        return;
      end
      e++;
    end
    edge_q     = 3;
    steps_left = 0;
  endfunction

  function automatic void rasterize(input logic f, input logic [CoordBits-1:0] x, y,
                                    output bit got_res, output pixel_res_t r,
                                    output bit used);
    logic [CoordBits-1:0] mstep;
    got_res = 1'b0;
    r       = '0;
    used    = 1'b1;
    if (f == FuncAdd) begin
      if (drawing_q) begin
        used = 1'b0;
        return;
      end
      vtx_x[vtx_count] = x;
      vtx_y[vtx_count] = y;
      vtx_count++;
      if (vtx_count == NumVerts) begin
        vtx_count = 0;
        drawing_q = 1'b1;
        find_segment(0);
      end
      return;
    end
    if (!drawing_q) begin
      used = 1'b0;
      return;
    end
    got_res = 1'b1;
    if (edge_q >= 3 || steps_left == 0) begin
      r.done     = 1'b1;
      drawing_q  = 1'b0;
      edge_q     = 0;
      steps_left = 0;
      return;
    end
    r.pixel_valid = 1'b1;
    r.x           = cur_x;
    r.y           = cur_y;
    r.color       = pen_q;
    r.edge_no     = edge_q[EdgeBits-1:0];
    mstep = minor_neg ? '1 : CoordBits'(1);
    if (decision > 0) begin
      decision += 2 * (d_minor - d_major);
      if (xmaj) cur_y += mstep;
      else      cur_x += mstep;
    end else begin
      decision += 2 * d_minor;
    end
    if (xmaj) cur_x += 1'b1;
    else      cur_y += 1'b1;
    steps_left--;
    if (steps_left == 0) find_segment(edge_q + 1);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    pixel_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_done_res) dones_seen++;
      else              pixels_seen++;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result: expected none, got pix=%0b x=%0d y=%0d done=%0b",
                 $time, out_pixel_valid, out_pixel_x, out_pixel_y, out_done_res);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_valid", want.pixel_valid, out_pixel_valid);
        check_field("pixel_x", want.x, out_pixel_x);
        check_field("pixel_y", want.y, out_pixel_y);
        check_field("pixel_color", want.color, out_pixel_color);
        check_field("edge_number", want.edge_no, out_edge_number);
        check_field("done_res", want.done, out_done_res);
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  task automatic transfer_item(input logic f, input logic [CoordBits-1:0] x, y,
                               input bit typed, input bit typed_has,
                               input pixel_res_t typed_r);
    bit         got_res;
    bit         used;
    pixel_res_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_vertex_x <= x;
    in_vertex_y <= y;
    do @(posedge clk); while (!in_ready);
    rasterize(f, x, y, got_res, r, used);
    if (used) useful++;
    if (typed ? typed_has : got_res)
      expected_pixels.insert(expected_pixels.size(), typed ? typed_r : r);
  endtask

  // Hold the sender until every result is back, then let the engine run dry.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic pen_write(input logic [ColorBits-1:0] colour);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= PenColorAddr;
    cfg_pwdata  <= {8'h00, colour};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    pen_q = colour;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata[ColorBits-1:0] !== pen_q) begin
      $display("%0t: pen_color readback mismatch: expected %0h, got %0h",
               $time, pen_q, cfg_prdata[ColorBits-1:0]);
      errors++;
    end
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    colours_written++;
  endtask

  initial begin : stimulus
    stim_row_t            row;
    pixel_res_t           typed_r;
    logic [CoordBits-1:0] big_x [3];
    logic [CoordBits-1:0] big_y [3];
    int                   ox [3];
    int                   oy [3];
    int                   bx, by, d, mode, burst;
    logic [ColorBits-1:0] sweep [4];

    sweep = '{24'hFFFFFF, 24'h000000, 24'h555555, 24'hAAAAAA};
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_func     <= FuncAdd;
    in_vertex_x <= '0;
    in_vertex_y <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= PenColorAddr;
    cfg_pwdata  <= '0;
    vtx_count  = 0;
    drawing_q  = 1'b0;
    edge_q     = 0;
    steps_left = 0;
    decision   = 0;
    pen_q      = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run with the pen still at its reset value.
    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      repeat (row.reps) begin
        typed_r = '0;
        if (row.kind == ExpDone) typed_r.done = 1'b1;
        if (row.kind == ExpPixel) begin
          typed_r.pixel_valid = 1'b1;
          typed_r.x           = row.px;
          typed_r.y           = row.py;
          typed_r.color       = pen_q;
          typed_r.edge_no     = row.edge_no;
        end
        transfer_item(row.func, row.vx, row.vy, row.kind != ExpModel,
                      row.kind == ExpDone || row.kind == ExpPixel, typed_r);
      end
    end

    // Two larger triangles: one in the corner of the range, one placed at random.
    settle();
    pen_write(sweep[0]);
    for (int t = 0; t < 2; t++) begin
      if (t == 0) begin
        big_x = '{11'd2047, 11'd1792, 11'd1792};
        big_y = '{11'd0, 11'd255, 11'd0};
      end else begin
        bx = $urandom_range(0, 1792);
        by = $urandom_range(0, 1792);
        for (int v = 0; v < 3; v++) begin
          big_x[v] = 11'(bx + $urandom_range(0, 255));
          big_y[v] = 11'(by + $urandom_range(0, 255));
        end
      end
      for (int v = 0; v < 3; v++) transfer_item(FuncAdd, big_x[v], big_y[v], 1'b0, 1'b0, '0);
      while (drawing_q) transfer_item(FuncStep, 11'($urandom), 11'($urandom), 1'b0, 1'b0, '0);
      triangles_sent++;
    end

    burst  = 0;
    while (useful < RandomItems) begin
      if (burst % 8 == 0 && !calm) begin
        settle();
        pen_write((colours_written < 4) ? sweep[colours_written] : 24'($urandom));
      end
      burst++;
      calm = useful > RandomItems * 17 / 20;
      if ($urandom_range(0, 99) < 80) begin
        // Small triangle with zero-length and tie edges mixed in
        bx = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 0 : 1984)
                                         : $urandom_range(0, 1984);
        by = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 0 : 1984)
                                         : $urandom_range(0, 1984);
        for (int v = 0; v < 3; v++) begin
          mode = $urandom_range(0, 9);
          if (v > 0 && mode == 0) begin
            ox[v] = ox[v-1];
            oy[v] = oy[v-1];
          end else if (v > 0 && mode <= 2) begin
            d = $urandom_range(0, 15);
            ox[v] = ox[v-1] + d;
            oy[v] = ($urandom_range(0, 1) || oy[v-1] < d) ? oy[v-1] + d : oy[v-1] - d;
          end else begin
            ox[v] = $urandom_range(0, 31);
            oy[v] = $urandom_range(0, 31);
          end
          transfer_item(FuncAdd, 11'(bx + ox[v]), 11'(by + oy[v]), 1'b0, 1'b0, '0);
          // broken sequence: stray steps between vertices are dropped
          if (v < 2 && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
              transfer_item(FuncStep, 11'($urandom), 11'($urandom), 1'b0, 1'b0, '0);
        end
        while (drawing_q) begin
          if ($urandom_range(0, 19) == 0)
            transfer_item(FuncAdd, 11'($urandom), 11'($urandom), 1'b0, 1'b0, '0);
          else
            transfer_item(FuncStep, 11'($urandom), 11'($urandom), 1'b0, 1'b0, '0);
        end
        triangles_sent++;
      end else begin
        repeat ($urandom_range(1, 4))
          transfer_item(FuncStep, 11'($urandom), 11'($urandom), 1'b0, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Drew %0d triangles: %0d pixels and %0d done results checked,", triangles_sent,
             pixels_seen, dones_seen);
    $display("with %0d pen colour writes, dropped items and receiver stalls mixed in.",
             colours_written);
    if (errors == 0) $display("triangle_outline_rasterizer_tb: PASS");
    else             $display("triangle_outline_rasterizer_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tor_pkg.sv
rtl/tor_front.sv
rtl/tor_back.sv
rtl/triangle_outline_rasterizer.sv
test/triangle_outline_rasterizer_tb.sv
